FILE: design/sts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sts_pkg - shared types and constants for the sorted table search block
// Field widths, item kinds, probe limit and the sequencer state type.
// ---------------------------------------------------------------------------
package sts_pkg;

  localparam int KEY_W   = 32;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int PROBE_W = 4;

  localparam logic [PROBE_W-1:0] PROBE_MAX = 4'd15;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } sts_state_t;

endpackage
`default_nettype wire

FILE: design/sts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sts_ram - key table storage
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module sts_ram
  import sts_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [KEY_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: design/sts_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sts_search - binary search sequencer
// Takes load and search items, drives the table ports and probes one
// midpoint per cycle, narrowing the [low, high) window on each compare.
// ---------------------------------------------------------------------------
module sts_search
  import sts_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_kind,
  input  wire logic [IDX_W-1:0]   in_entry_index,
  input  wire logic [KEY_W-1:0]   in_key,
  input  wire logic [CNT_W-1:0]   entry_count,
  output logic                    wr_en,
  output logic      [AW-1:0]      wr_addr,
  output logic      [KEY_W-1:0]   wr_data,
  output logic                    rd_en,
  output logic      [AW-1:0]      rd_addr,
  input  wire logic [KEY_W-1:0]   rd_data,
  output logic                    out_valid,
  output logic                    out_found,
  output logic      [IDX_W-1:0]   out_position,
  output logic      [PROBE_W-1:0] out_probes
);

  localparam int BW = AW + 1;   // window bounds reach DEPTH

  sts_state_t state_r, state_nxt;

  logic [BW-1:0]      low_r, low_nxt;
  logic [BW-1:0]      high_r, high_nxt;  // exclusive upper bound
  logic [AW-1:0]      mid_r, mid_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PROBE_W-1:0] probes_r, probes_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [IDX_W-1:0]   out_position_r, out_position_nxt;
  logic [PROBE_W-1:0] out_probes_r, out_probes_nxt;

  logic               accept;
  logic [BW-1:0]      n_used;
  logic [BW:0]        first_sum;
  logic [BW-1:0]      cand_low, cand_high;
  logic [BW:0]        cand_sum;
  logic [PROBE_W-1:0] probes_inc;
  logic               key_eq, key_gt;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // clamp the count to the table size
  assign n_used = (32'(entry_count) > DEPTH) ? BW'(DEPTH) : BW'(entry_count);

  assign first_sum  = {1'b0, n_used} - (BW + 1)'(1);
  assign key_eq     = (rd_data == key_r);
  assign key_gt     = ($signed(rd_data) > $signed(key_r));
  assign probes_inc = (probes_r == PROBE_MAX) ? PROBE_MAX : probes_r + PROBE_W'(1);

  assign cand_low  = key_gt ? low_r : (BW'(mid_r) + BW'(1));
  assign cand_high = key_gt ? BW'(mid_r) : high_r;
  assign cand_sum  = {1'b0, cand_low} + {1'b0, cand_high} - (BW + 1)'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_SEARCH) && (n_used != '0)) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (key_eq || (cand_low >= cand_high)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    low_nxt          = low_r;
    high_nxt         = high_r;
    mid_nxt          = mid_r;
    key_nxt          = key_r;
    probes_nxt       = probes_r;
    out_valid_nxt    = 1'b0;
    out_found_nxt    = out_found_r;
    out_position_nxt = out_position_r;
    out_probes_nxt   = out_probes_r;
    wr_en            = 1'b0;
    wr_addr          = AW'(in_entry_index);
    wr_data          = in_key;
    rd_en            = 1'b0;
    rd_addr          = first_sum[AW:1];
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_LOAD)) begin
          wr_en = (32'(in_entry_index) < DEPTH);
        end else if (accept) begin
          key_nxt    = in_key;
          probes_nxt = '0;
          if (n_used == '0) begin
            // empty table: answer at once
            out_valid_nxt    = 1'b1;
            out_found_nxt    = 1'b0;
            out_position_nxt = '0;
            out_probes_nxt   = '0;
          end else begin
            low_nxt  = '0;
            high_nxt = n_used;
            mid_nxt  = first_sum[AW:1];
            rd_en    = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        probes_nxt = probes_inc;
        low_nxt    = cand_low;
        high_nxt   = cand_high;
        if (key_eq) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = 1'b1;
          out_position_nxt = IDX_W'(mid_r);
          out_probes_nxt   = probes_inc;
        end else if (cand_low >= cand_high) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = 1'b0;
          out_position_nxt = '0;
          out_probes_nxt   = probes_inc;
        end else begin
          // issue the next probe straight from the compare
          mid_nxt = cand_sum[AW:1];
          rd_addr = cand_sum[AW:1];
          rd_en   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r          <= low_nxt;
    high_r         <= high_nxt;
    mid_r          <= mid_nxt;
    key_r          <= key_nxt;
    probes_r       <= probes_nxt;
    out_found_r    <= out_found_nxt;
    out_position_r <= out_position_nxt;
    out_probes_r   <= out_probes_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_probes   = out_probes_r;

endmodule
`default_nettype wire

FILE: design/sorted_table_binary_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_table_binary_search - binary search over a loaded key table
// Results: a load gives no result. A search with k
//   probes (k <= log2(DEPTH)+1) holds busy while it probes and shows its
//   result on out_valid in the first cycle with busy low;
//   an empty table answers in the cycle after start.
// Throughput: one probe per cycle, set by the table's single read port;
//   a new item is taken only while busy is low, and a search holds busy
//   until its last probe. The receiver cannot stall.
// Reset: synchronous; clears the sequencer and entry_count, the table
//   itself is not cleared.
// ---------------------------------------------------------------------------
module sorted_table_binary_search
  import sts_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_kind,
  input  wire logic [IDX_W-1:0]   in_entry_index,
  input  wire logic [KEY_W-1:0]   in_key,
  output logic                    out_valid,
  output logic                    out_found,
  output logic      [IDX_W-1:0]   out_position,
  output logic      [PROBE_W-1:0] out_probes,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CNT_W-1:0]   cfg_data
);

  localparam int AW = $clog2(DEPTH);

  logic [CNT_W-1:0] entry_count_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count_r <= cfg_data;
    end
  end

  sts_search #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_search (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_key         (in_key),
    .entry_count    (entry_count_r),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_position   (out_position),
    .out_probes     (out_probes)
  );

  sts_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

FILE: design/sts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sts_checker - port-level checks for the sorted table search block
// Watches the handshake and result ports; attached by bind.
// ---------------------------------------------------------------------------
module sts_checker
  import sts_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               in_kind,
  input wire logic               out_valid,
  input wire logic               out_found,
  input wire logic [IDX_W-1:0]   out_position,
  input wire logic [PROBE_W-1:0] out_probes
);

  // a result comes only once the search is done
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // busy rises only after an accepted search item
  a_busy_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> ($past(start) && ($past(in_kind) == KIND_SEARCH)))
    else $error("busy without an accepted search");

  // a miss reports position zero
  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("miss with nonzero position");

  // a hit needs at least one probe
  a_hit_probes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_probes != '0))
    else $error("hit with zero probes");

endmodule

bind sorted_table_binary_search sts_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_kind      (in_kind),
  .out_valid    (out_valid),
  .out_found    (out_found),
  .out_position (out_position),
  .out_probes   (out_probes)
);
`default_nettype wire
